// ===== sv/rpag_pkg.sv =====
package rpag_pkg;

	localparam int SMP_W      = 16;
	localparam int LVL_W      = 16;
	localparam int SID_W      = 4;
	localparam int TS_W       = 48;
	localparam int SQ_W       = 2 * LVL_W;
	localparam int SQRT_STEPS = LVL_W;
	localparam int SREM_W     = LVL_W + 1;

	localparam logic REG_ACTIVE  = 1'b0;
	localparam logic REG_SILENCE = 1'b1;

	localparam logic [LVL_W-1:0] ACTIVE_RESET  = 16'd328;
	localparam logic [LVL_W-1:0] SILENCE_RESET = 16'd164;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_value;
		logic                    last_sample;
		logic [SID_W-1:0]        stream_id;
		logic [TS_W-1:0]         time_stamp;
	} sample_t;

	typedef struct packed {
		logic [SID_W-1:0] event_stream;
		logic [LVL_W-1:0] rms_value;
		logic [LVL_W-1:0] peak_value;
		logic [TS_W-1:0]  event_time;
	} event_t;

	typedef enum logic [6:0] {
		ST_ACC    = 7'b0000001,
		ST_FLUSH1 = 7'b0000010,
		ST_FLUSH2 = 7'b0000100,
		ST_LOAD   = 7'b0001000,
		ST_DIV    = 7'b0010000,
		ST_SQRT   = 7'b0100000,
		ST_DECIDE = 7'b1000000
	} state_t;

	typedef struct packed {
		logic take;
		logic load;
		logic div_step;
		logic sqrt_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic audible;
		logic in_range;
		logic out_busy;
	} sts_t;

endpackage

// ===== sv/rpag_stream_if.sv =====
interface rpag_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rpag_ctrl.sv =====
module rpag_ctrl
	import rpag_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic smp_valid,
	input  logic smp_last,
	input  sts_t sts,
	output logic smp_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d       = state_q;
		smp_ready     = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_ACC: begin
				smp_ready = 1'b1;
				cmd.take  = smp_valid;
				if (smp_valid && smp_last) begin
					state_d = ST_FLUSH1;
				end
			end
			ST_FLUSH1: begin
				state_d = ST_FLUSH2;
			end
			ST_FLUSH2: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				// hold while an audible result would overwrite a pending word
				if (!(sts.in_range && sts.audible && sts.out_busy)) begin
					cmd.commit = 1'b1;
					state_d    = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/rpag_dp.sv =====
module rpag_dp
	import rpag_pkg::*;
#(
	parameter int NUM_STREAMS = 16,
	parameter int MAX_SAMPLES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sample_t          smp_data,
	input  cmd_t             cmd,
	input  logic [LVL_W-1:0] act_thr,
	input  logic [LVL_W-1:0] sil_thr,
	input  logic             evt_ready,
	output logic             evt_valid,
	output event_t           evt_data,
	output sts_t             sts
);

	localparam int TW    = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = TW + SQ_W - 1;
	localparam int CNT_W = $clog2(SUM_W);

	logic [SMP_W-1:0]  raw;
	logic [LVL_W-1:0]  mag;
	logic              room;

	logic [LVL_W-1:0]  mag_s1;
	logic              take_s1;
	logic [SQ_W-1:0]   sq_s2;
	logic              take_s2;

	logic [SUM_W-1:0]  sum_q;
	logic [LVL_W-1:0]  peak_q;
	logic [TW-1:0]     tally_q;
	logic [SID_W-1:0]  sid_q;
	logic [TS_W-1:0]   ts_q;

	logic [TW-1:0]     dvs_q;
	logic [TW-1:0]     rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [LVL_W-1:0]  pk_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SREM_W-1:0] srem_q;
	logic [LVL_W-1:0]  root_q;

	logic [TW:0]       div_sh;
	logic              div_ge;
	logic [SREM_W+1:0] sq_sh;
	logic [SREM_W+1:0] sq_trial;
	logic              sq_ge;

	logic [NUM_STREAMS-1:0] flags_q;
	logic              flag_cur;
	logic              in_range;
	logic              audible;

	logic              out_valid_q;
	event_t            out_q;

	assign raw  = unsigned'(smp_data.sample_value);
	assign mag  = raw[SMP_W-1] ? (~raw + 16'd1) : raw;
	assign room = tally_q < TW'(MAX_SAMPLES);

	assign div_sh   = {rem_q, quo_q[SUM_W-1]};
	assign div_ge   = div_sh >= {1'b0, dvs_q};
	assign sq_sh    = {srem_q, quo_q[SQ_W-1:SQ_W-2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;

	assign in_range = 32'(sid_q) < 32'(NUM_STREAMS);

	always_comb begin
		flag_cur = 1'b0;
		for (int i = 0; i < NUM_STREAMS; i++) begin
			if (32'(sid_q) == 32'(i)) begin
				flag_cur = flags_q[i];
			end
		end
	end

	assign audible = flag_cur ? (root_q >= sil_thr) : (root_q >= act_thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1     <= 1'b0;
			take_s2     <= 1'b0;
			sum_q       <= '0;
			peak_q      <= '0;
			tally_q     <= '0;
			cnt_q       <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			take_s1 <= cmd.take && room;
			take_s2 <= take_s1;
			if (cmd.take && room) begin
				tally_q <= tally_q + TW'(1);
			end
			if (take_s1 && (mag_s1 > peak_q)) begin
				peak_q <= mag_s1;
			end
			if (take_s2) begin
				sum_q <= sum_q + SUM_W'(sq_s2);
			end
			if (cmd.load) begin
				sum_q   <= '0;
				peak_q  <= '0;
				tally_q <= '0;
				cnt_q   <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= sts.div_done ? '0 : cnt_q + CNT_W'(1);
			end else if (cmd.sqrt_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.commit && in_range) begin
				for (int i = 0; i < NUM_STREAMS; i++) begin
					if (32'(sid_q) == 32'(i)) begin
						flags_q[i] <= audible;
					end
				end
			end
			if (cmd.commit && in_range && audible) begin
				out_valid_q <= 1'b1;
			end else if (evt_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		sq_s2  <= SQ_W'(mag_s1) * SQ_W'(mag_s1);
		if (cmd.take) begin
			sid_q <= smp_data.stream_id;
			ts_q  <= smp_data.time_stamp;
		end
		if (cmd.load) begin
			dvs_q  <= tally_q;
			rem_q  <= '0;
			quo_q  <= sum_q;
			pk_q   <= peak_q;
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? TW'(div_sh - {1'b0, dvs_q}) : div_sh[TW-1:0];
			quo_q <= {quo_q[SUM_W-2:0], div_ge};
		end else if (cmd.sqrt_step) begin
			srem_q <= sq_ge ? SREM_W'(sq_sh - sq_trial) : sq_sh[SREM_W-1:0];
			root_q <= {root_q[LVL_W-2:0], sq_ge};
			quo_q  <= {quo_q[SUM_W-3:0], 2'b00};
		end
		if (cmd.commit && in_range && audible) begin
			out_q.event_stream <= sid_q;
			out_q.rms_value    <= root_q;
			out_q.peak_value   <= pk_q;
			out_q.event_time   <= ts_q;
		end
	end

	assign sts.div_done  = cnt_q == CNT_W'(SUM_W - 1);
	assign sts.sqrt_done = cnt_q == CNT_W'(SQRT_STEPS - 1);
	assign sts.audible   = audible;
	assign sts.in_range  = in_range;
	assign sts.out_busy  = out_valid_q;

	assign evt_valid = out_valid_q;
	assign evt_data  = out_q;

endmodule

// ===== sv/rms_peak_activity_gate.sv =====
// channel  dir  handshake       word
// smp      in   valid/ready     sample_t: sample, last marker, stream id, timestamp
// evt      out  valid/ready     event_t: stream, rms, peak, time
// apb      in   psel/penable    active_threshold at 0x0, silence_threshold at 0x4
//
// One sample per cycle within a buffer. After the last sample the input stalls for
// SUM_W + 20 cycles (64 at the default sizes): three to drain the square/accumulate
// pipeline, SUM_W for the bit-serial mean divider, 16 for the square root, one for
// the hysteresis update, longer if an event must wait for the output register.
// Reset clears accumulators, stream flags and thresholds to their defaults.
module rms_peak_activity_gate
	import rpag_pkg::*;
#(
	parameter int NUM_STREAMS = 16,
	parameter int MAX_SAMPLES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	rpag_stream_if.sink   smp,
	rpag_stream_if.source evt,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cmd_t             cmd;
	sts_t             sts;
	sample_t          smp_word;
	event_t           evt_word;
	logic [LVL_W-1:0] act_q;
	logic [LVL_W-1:0] sil_q;
	logic [LVL_W-1:0] rd_val;

	assign smp_word = smp.data;
	assign evt.data = evt_word;
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACTIVE_RESET;
			sil_q <= SILENCE_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_ACTIVE:  act_q <= pwdata[LVL_W-1:0];
				REG_SILENCE: sil_q <= pwdata[LVL_W-1:0];
				default:     act_q <= act_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ACTIVE:  rd_val = act_q;
			REG_SILENCE: rd_val = sil_q;
			default:     rd_val = '0;
		endcase
	end

	assign prdata = 32'(rd_val);

	rpag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp.valid),
		.smp_last  (smp_word.last_sample),
		.sts       (sts),
		.smp_ready (smp.ready),
		.cmd       (cmd)
	);

	rpag_dp #(
		.NUM_STREAMS (NUM_STREAMS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_data  (smp_word),
		.cmd       (cmd),
		.act_thr   (act_q),
		.sil_thr   (sil_q),
		.evt_ready (evt.ready),
		.evt_valid (evt.valid),
		.evt_data  (evt_word),
		.sts       (sts)
	);

`ifndef ASSERT_OFF
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		smp.valid && smp.ready && smp_word.last_sample |=> !smp.ready)
		else $error("input not held off after last sample");

	a_evt_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(evt.valid) |-> $past(cmd.commit))
		else $error("event raised without a hysteresis commit");

	a_evt_stream: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> 32'(evt_word.event_stream) < 32'(NUM_STREAMS))
		else $error("event for a stream out of range");

	a_evt_levels: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> evt_word.rms_value <= 16'd32768 && evt_word.peak_value <= 16'd32768)
		else $error("event level above full scale");
`endif

endmodule

// ===== tb/tb_rms_peak_activity_gate.sv =====
module tb_rms_peak_activity_gate;
	import rpag_pkg::*;

	localparam int MAX_SAMPLES   = 4096;
	localparam int SETTLE_CYCLES = 120;
	localparam int QUIET_LIMIT   = 5000;
	localparam int PHASE_WORDS   = 220;

	class activity_scoreboard;
		logic [LVL_W-1:0] active_thr;
		logic [LVL_W-1:0] silence_thr;
		logic [42:0]      square_acc;
		logic [16:0]      peak_mag;
		logic [12:0]      tally;
		bit               stream_on[16];
		event_t           due_events[$];
		int               errors;

		function new();
			active_thr  = ACTIVE_RESET;
			silence_thr = SILENCE_RESET;
			square_acc  = '0;
			peak_mag    = '0;
			tally       = '0;
			foreach (stream_on[i]) stream_on[i] = 1'b0;
			errors      = 0;
		endfunction

		function void set_threshold(logic idx, logic [LVL_W-1:0] value);
			if (idx == REG_ACTIVE)
				active_thr = value;
			else
				silence_thr = value;
		endfunction

		function logic [16:0] floor_sqrt(logic [42:0] v);
			logic [16:0] root;
			logic [16:0] trial;
			logic [63:0] sq;
			int b;
			root = '0;
			for (b = 16; b >= 0; b--) begin
				trial = root | (17'd1 << b);
				sq = 64'(trial) * 64'(trial);
				if (sq <= 64'(v))
					root = trial;
			end
			return root;
		endfunction

		function void note_sample(sample_t s);
			int          mag;
			logic [16:0] rms;
			logic [42:0] mean;
			bit          loud;
			event_t      ev;
			mag = $signed(s.sample_value);
			if (mag < 0)
				mag = -mag;
			if (tally < 13'(MAX_SAMPLES)) begin
				square_acc = square_acc + 43'(longint'(mag) * longint'(mag));
				if (17'(mag) > peak_mag)
					peak_mag = 17'(mag);
				tally = tally + 13'd1;
			end
			if (!s.last_sample)
				return;
			mean = (tally != 0) ? square_acc / 43'(tally) : '0;
			rms = floor_sqrt(mean);
			ev.event_stream = s.stream_id;
			ev.rms_value    = rms[LVL_W-1:0];
			ev.peak_value   = peak_mag[LVL_W-1:0];
			ev.event_time   = s.time_stamp;
			square_acc = '0;
			peak_mag   = '0;
			tally      = '0;
			if (stream_on[s.stream_id])
				loud = rms >= 17'(silence_thr);
			else
				loud = rms >= 17'(active_thr);
			stream_on[s.stream_id] = loud;
			if (loud)
				due_events.push_back(ev);
		endfunction

		function void field_ok(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_event(event_t got);
			event_t want;
			if (due_events.size() == 0) begin
				errors++;
				$display("%0t: event expected none, got stream %0d rms %0d peak %0d time %0d",
					$time, got.event_stream, got.rms_value, got.peak_value, got.event_time);
				return;
			end
			want = due_events.pop_front();
			field_ok("event_stream", 64'(want.event_stream), 64'(got.event_stream));
			field_ok("rms_value", 64'(want.rms_value), 64'(got.rms_value));
			field_ok("peak_value", 64'(want.peak_value), 64'(got.peak_value));
			field_ok("event_time", 64'(want.event_time), 64'(got.event_time));
		endfunction

		function int pending();
			return due_events.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int send_idle;
	int recv_idle;
	int quiet_cycles;

	activity_scoreboard board = new();

	rpag_stream_if #(.T(sample_t)) smp_if ();
	rpag_stream_if #(.T(event_t))  evt_if ();

	rms_peak_activity_gate #(
		.NUM_STREAMS(16),
		.MAX_SAMPLES(MAX_SAMPLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.smp(smp_if),
		.evt(evt_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		evt_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			evt_if.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && evt_if.valid && evt_if.ready)
			board.check_event(evt_if.data);
	end

	always @(posedge clk) begin
		if ((smp_if.valid && smp_if.ready) || (evt_if.valid && evt_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic sample_t make_sample(logic [15:0] value, logic last,
		logic [3:0] sid, logic [47:0] ts);
		sample_t w;
		w.sample_value = value;
		w.last_sample  = last;
		w.stream_id    = sid;
		w.time_stamp   = ts;
		return w;
	endfunction

	function automatic logic [47:0] rand_ts();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [15:0] pick_sample(int level);
		logic [15:0] mag;
		case (level)
			0: return 16'h0000;
			1: mag = 16'($urandom_range(0, 400));
			2: mag = 16'($urandom_range(0, 4000));
			3: return 16'($urandom);
			4: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			default: return 16'h8000;
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic int pick_level();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r <= 2) return 1;
		if (r <= 5) return 2;
		if (r <= 7) return 3;
		if (r == 8) return 4;
		return 5;
	endfunction

	task automatic set_mode(int mode);
		case (mode)
			0: begin
				send_idle = 26;
				recv_idle = 66;
			end
			1: begin
				send_idle = 66;
				recv_idle = 26;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
		endcase
	endtask

	task automatic push_sample(sample_t w);
		while ($urandom_range(0, 99) < send_idle) begin
			smp_if.valid <= 1'b0;
			@(posedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.data  <= w;
		@(posedge clk);
		while (!smp_if.ready)
			@(posedge clk);
		board.note_sample(w);
	endtask

	task automatic send_buffer(int len, int level, int tail, int tail_level, logic [3:0] sid);
		int i;
		for (i = 0; i < len; i++)
			push_sample(make_sample(pick_sample((i >= len - tail) ? tail_level : level),
				i == len - 1, (i == len - 1) ? sid : 4'($urandom), rand_ts()));
	endtask

	task automatic random_buffers(int count);
		int sent;
		int len;
		logic [3:0] sid;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160) : $urandom_range(1, 24);
			sid = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
				4'($urandom_range(0, 3));
			send_buffer(len, pick_level(), 0, 0, sid);
			sent += len;
		end
	endtask

	task automatic settle();
		smp_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(logic idx, logic write, logic [LVL_W-1:0] value,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
	endtask

	task automatic program_thresholds(logic [LVL_W-1:0] active, logic [LVL_W-1:0] silence);
		logic [31:0] rdata;
		apb_access(REG_ACTIVE, 1'b1, active, rdata);
		board.set_threshold(REG_ACTIVE, active);
		apb_access(REG_SILENCE, 1'b1, silence, rdata);
		board.set_threshold(REG_SILENCE, silence);
		apb_access(REG_ACTIVE, 1'b0, '0, rdata);
		board.field_ok("active_threshold", 64'(active), 64'(rdata[LVL_W-1:0]));
		apb_access(REG_SILENCE, 1'b0, '0, rdata);
		board.field_ok("silence_threshold", 64'(silence), 64'(rdata[LVL_W-1:0]));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		quiet_cycles = 0;
		arst_n       <= 1'b0;
		smp_if.valid <= 1'b0;
		smp_if.data  <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		set_mode(0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale single words, including the most negative sample
		push_sample(make_sample(16'h8000, 1'b1, 4'd15, '1));
		push_sample(make_sample(16'h7FFF, 1'b1, 4'd0, '0));
		// silent buffer drops an active stream
		push_sample(make_sample(16'h0000, 1'b0, 4'd0, rand_ts()));
		push_sample(make_sample(16'h0000, 1'b0, 4'd0, rand_ts()));
		push_sample(make_sample(16'h0000, 1'b1, 4'd0, rand_ts()));
		push_sample(make_sample(16'hFFFF, 1'b0, 4'd3, rand_ts()));
		push_sample(make_sample(16'h0001, 1'b0, 4'd3, rand_ts()));
		push_sample(make_sample(16'h0000, 1'b1, 4'd3, rand_ts()));
		// hysteresis walk at the threshold edges
		push_sample(make_sample(16'd328, 1'b1, 4'd5, rand_ts()));
		push_sample(make_sample(16'd200, 1'b1, 4'd5, rand_ts()));
		push_sample(make_sample(-16'sd164, 1'b1, 4'd5, rand_ts()));
		push_sample(make_sample(16'd163, 1'b1, 4'd5, rand_ts()));
		push_sample(make_sample(16'd200, 1'b1, 4'd5, rand_ts()));
		push_sample(make_sample(16'd327, 1'b1, 4'd6, rand_ts()));
		push_sample(make_sample(16'h7FFF, 1'b0, 4'd9, rand_ts()));
		push_sample(make_sample(16'h8000, 1'b0, 4'd9, rand_ts()));
		push_sample(make_sample(16'd100, 1'b0, 4'd9, rand_ts()));
		push_sample(make_sample(-16'sd100, 1'b1, 4'd9, rand_ts()));
		random_buffers(PHASE_WORDS);

		settle();
		program_thresholds(16'd0, 16'd0);
		random_buffers(PHASE_WORDS);

		settle();
		set_mode(1);
		program_thresholds(16'd32768, 16'd32768);
		random_buffers(PHASE_WORDS);

		settle();
		program_thresholds(16'hFFFF, 16'd0);
		random_buffers(PHASE_WORDS);

		settle();
		set_mode(2);
		program_thresholds(16'd2000, 16'd500);
		random_buffers(PHASE_WORDS);

		settle();
		program_thresholds(16'd500, 16'd2000);
		random_buffers(PHASE_WORDS);

		settle();
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
